>>> sv/gb_pkg.sv
// gb_pkg: shared types, constants and kernel weights for the 5x5 Gaussian blur.
// Used by gb_linebuf, gb_lane and gaussian_blur_5x5_rgb. No dependencies.

package gb_pkg;

	// Default geometry limits
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Register reset values
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	// Field widths
	localparam int IMG_W_W   = 12;
	localparam int IMG_H_W   = 13;
	localparam int OUT_COL_W = 11;
	localparam int OUT_ROW_W = 12;
	localparam int CH_W      = 8;
	localparam int NUM_CH    = 3;
	localparam int PIX_W     = NUM_CH * CH_W;
	localparam int KSIZE     = 5;

	// Kernel weights (scaled by 1000), grouped by symmetry class
	localparam int WT_CORNER = 3;    // four corners
	localparam int WT_EDGE1  = 13;   // eight outer ring, next to corners
	localparam int WT_EDGE2  = 22;   // four outer ring, middle
	localparam int WT_INNER1 = 59;   // four inner diagonals
	localparam int WT_INNER2 = 97;   // four inner orthogonals
	localparam int WT_CENTER = 159;  // center tap

	// Lane arithmetic widths
	localparam int G4_W  = CH_W + 2;   // sum of four bytes
	localparam int G8_W  = CH_W + 3;   // sum of eight bytes
	localparam int SUM_W = 18;         // max 987*255 = 251685

	// floor(x/1000) = (x * RECIP_M) >> RECIP_SH, exact for x < 2^SUM_W
	localparam int RECIP_SH = 28;
	localparam int RECIP_W  = 19;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(268436);
	localparam int PROD_W = SUM_W + RECIP_W;

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [KSIZE-1:0][KSIZE-1:0][CH_W-1:0] win8_t;

	// Stage enables handed to the channel lanes
	typedef struct packed {
		logic en3;
		logic en4;
	} lane_ctl_t;

endpackage

>>> sv/gb_linebuf.sv
// gb_linebuf: one row of pixel storage, read-before-write at a shared address.
// Depends on gb_pkg.

module gb_linebuf #(
	parameter int DEPTH = gb_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           rd_en,
	input  logic           we,
	input  logic [AW-1:0]  addr,
	input  gb_pkg::pix_t   wdata,
	output gb_pkg::pix_t   rdata
);
	import gb_pkg::*;

	pix_t mem [DEPTH];
	pix_t rd_q;

	// Registered read returns the old entry when the same address is written
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[addr];
		end
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	assign rdata = rd_q;

endmodule

>>> sv/gb_lane.sv
// gb_lane: 5x5 Gaussian convolution of one color channel, two register stages,
// then reciprocal divide by 1000. Depends on gb_pkg.

module gb_lane (
	input  logic              clk,
	input  gb_pkg::lane_ctl_t ctl,
	input  gb_pkg::win8_t     win,
	output gb_pkg::chan_t     q
);
	import gb_pkg::*;

	logic [G4_W-1:0]   g3_s3, g22_s3, g59_s3, g97_s3;
	logic [G8_W-1:0]   g13_s3;
	chan_t             c_s3;
	logic [SUM_W-1:0]  sum_s4;
	logic [PROD_W-1:0] prod;

	// Stage 3: fold taps that share a weight
	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			g3_s3  <= G4_W'(win[0][0]) + G4_W'(win[0][4]) + G4_W'(win[4][0]) + G4_W'(win[4][4]);
			g13_s3 <= G8_W'(win[0][1]) + G8_W'(win[0][3]) + G8_W'(win[1][0]) + G8_W'(win[1][4])
			        + G8_W'(win[3][0]) + G8_W'(win[3][4]) + G8_W'(win[4][1]) + G8_W'(win[4][3]);
			g22_s3 <= G4_W'(win[0][2]) + G4_W'(win[2][0]) + G4_W'(win[2][4]) + G4_W'(win[4][2]);
			g59_s3 <= G4_W'(win[1][1]) + G4_W'(win[1][3]) + G4_W'(win[3][1]) + G4_W'(win[3][3]);
			g97_s3 <= G4_W'(win[1][2]) + G4_W'(win[2][1]) + G4_W'(win[2][3]) + G4_W'(win[3][2]);
			c_s3   <= win[2][2];
		end
	end

	// Stage 4: weighted sum, constant multiplies only
	always_ff @(posedge clk) begin
		if (ctl.en4) begin
			sum_s4 <= SUM_W'(g3_s3)  * SUM_W'(WT_CORNER)
			        + SUM_W'(g13_s3) * SUM_W'(WT_EDGE1)
			        + SUM_W'(g22_s3) * SUM_W'(WT_EDGE2)
			        + SUM_W'(g59_s3) * SUM_W'(WT_INNER1)
			        + SUM_W'(g97_s3) * SUM_W'(WT_INNER2)
			        + SUM_W'(c_s3)   * SUM_W'(WT_CENTER);
		end
	end

	// floor(sum / 1000) by reciprocal multiply; result is at most 251
	assign prod = PROD_W'(sum_s4) * PROD_W'(RECIP_M);
	assign q    = prod[RECIP_SH +: CH_W];

endmodule

>>> sv/gaussian_blur_5x5_rgb.sv
// gaussian_blur_5x5_rgb: streaming 5x5 Gaussian blur of RGB pixels, top level.
// Depends on gb_pkg, gb_linebuf (four row buffers) and gb_lane (three channels).
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data     | in
//  pixel   | in_valid/in_ready, chan0..2, frame_start     | in
//  result  | out_valid/out_ready, out_col, out_row,       | out
//          | blur0..2, frame_done                         |
//
// One pixel per clock sustained while the output is not stalled; each pixel goes
// through the line buffer read at the edge that accepts it, then window shift,
// tap fold, weighted sum, divide into the output register.
// Each stage holds only while the stage after it is full and stalled, so an
// idle slot anywhere in the pipe still lets a new pixel in.
// Reset clears counters and valid bits and loads the reset sizes; line
// buffers are not cleared and need no clearing pass. cfg_ready is always high.

module gaussian_blur_5x5_rgb #(
	parameter int MAX_WIDTH  = gb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gb_pkg::chan_t                 chan0,
	input  gb_pkg::chan_t                 chan1,
	input  gb_pkg::chan_t                 chan2,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gb_pkg::OUT_COL_W-1:0]  out_col,
	output logic [gb_pkg::OUT_ROW_W-1:0]  out_row,
	output gb_pkg::chan_t                 blur0,
	output gb_pkg::chan_t                 blur1,
	output gb_pkg::chan_t                 blur2,
	output logic                          frame_done
);
	import gb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WX = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int HX = (RW + 1 > IMG_H_W) ? RW + 1 : IMG_H_W;
	localparam logic [WX-1:0] W_MAX = WX'(MAX_WIDTH);
	localparam logic [HX-1:0] H_MAX = HX'(MAX_HEIGHT);
	localparam logic [WX-1:0] W_RST = (RESET_WIDTH > MAX_WIDTH) ? W_MAX : WX'(RESET_WIDTH);
	localparam logic [HX-1:0] H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? H_MAX : HX'(RESET_HEIGHT);

	// Configuration: sizes stored already saturated
	logic [WX-1:0] eff_w_q, cfg_w;
	logic [HX-1:0] eff_h_q, cfg_h;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_w = WX'(cfg_data[IMG_W_W-1:0]);
		cfg_h = HX'(cfg_data[IMG_H_W-1:0]);
		if (cfg_w == '0) begin
			cfg_w = WX'(1);
		end else if (cfg_w > W_MAX) begin
			cfg_w = W_MAX;
		end
		if (cfg_h == '0) begin
			cfg_h = HX'(1);
		end else if (cfg_h > H_MAX) begin
			cfg_h = H_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= W_RST;
			eff_h_q <= H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  eff_w_q <= cfg_w;
				REG_HEIGHT: eff_h_q <= cfg_h;
				default: ;
			endcase
		end
	end

	// Pipeline handshake: each stage moves when the next one is free or moving
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic accept;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;

	// Position counters
	logic [CW-1:0] col_q, col_cur;
	logic [RW-1:0] row_q, row_cur;
	logic          emit, last, col_wrap, row_wrap;
	logic [CW+OUT_COL_W-1:0] col_ext;
	logic [RW+OUT_ROW_W-1:0] row_ext;

	always_comb begin
		col_cur  = frame_start ? '0 : col_q;
		row_cur  = frame_start ? '0 : row_q;
		emit     = (col_cur >= CW'(4)) && (row_cur >= RW'(4))
		        && (WX'(col_cur) < eff_w_q) && (HX'(row_cur) < eff_h_q);
		last     = (WX'(col_cur) == eff_w_q - WX'(1)) && (HX'(row_cur) == eff_h_q - HX'(1));
		col_wrap = (WX'(col_cur) + WX'(1)) >= eff_w_q;
		row_wrap = (HX'(row_cur) + HX'(1)) >= eff_h_q;
		// center sits two columns left and two rows up
		col_ext  = {OUT_COL_W'(0), col_cur - CW'(2)};
		row_ext  = {OUT_ROW_W'(0), row_cur - RW'(2)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_cur + RW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// Line buffers: bank (row & 3) gets the new pixel, all banks read the column
	pix_t in_pix;
	pix_t bank_rd [4];

	assign in_pix = {chan2, chan1, chan0};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		gb_linebuf #(
			.DEPTH (MAX_WIDTH),
			.AW    (CW)
		) u_linebuf (
			.clk   (clk),
			.rd_en (accept),
			.we    (accept && (row_cur[1:0] == 2'(b))),
			.addr  (col_cur),
			.wdata (in_pix),
			.rdata (bank_rd[b])
		);
	end

	// Stage 1: request in flight through the line buffer read
	logic                 emit_s1, last_s1;
	logic [1:0]           rsel_s1;
	logic [OUT_COL_W-1:0] col_s1;
	logic [OUT_ROW_W-1:0] row_s1;
	pix_t                 pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			last_s1 <= last;
			rsel_s1 <= row_cur[1:0];
			col_s1  <= col_ext[OUT_COL_W-1:0];
			row_s1  <= row_ext[OUT_ROW_W-1:0];
			pix_s1  <= in_pix;
		end
	end

	// Stage 2: 5x5 window shifts one column per request, column 4 newest
	logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_q;
	logic                 last_s2;
	logic [OUT_COL_W-1:0] col_s2;
	logic [OUT_ROW_W-1:0] row_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
			end
			for (int r = 0; r < KSIZE - 1; r++) begin
				win_q[r][KSIZE-1] <= bank_rd[2'(rsel_s1 + 2'(r))];
			end
			win_q[KSIZE-1][KSIZE-1] <= pix_s1;
			last_s2 <= last_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
		end
	end

	// Channel lanes
	win8_t     lane_win [NUM_CH];
	chan_t     lane_q   [NUM_CH];
	lane_ctl_t lane_ctl;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE; c++) begin
					lane_win[k][r][c] = win_q[r][c][k*CH_W +: CH_W];
				end
			end
		end
	end

	assign lane_ctl.en3 = en3;
	assign lane_ctl.en4 = en4;

	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		gb_lane u_lane (
			.clk (clk),
			.ctl (lane_ctl),
			.win (lane_win[k]),
			.q   (lane_q[k])
		);
	end

	// Stages 3 and 4: coordinates ride alongside the lanes
	logic                 last_s3, last_s4;
	logic [OUT_COL_W-1:0] col_s3, col_s4;
	logic [OUT_ROW_W-1:0] row_s3, row_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			last_s3 <= last_s2;
			col_s3  <= col_s2;
			row_s3  <= row_s2;
		end
		if (en4) begin
			last_s4 <= last_s3;
			col_s4  <= col_s3;
			row_s4  <= row_s3;
		end
	end

	// Stage 5: merge lane results into the output register
	logic                 last_s5;
	logic [OUT_COL_W-1:0] col_s5;
	logic [OUT_ROW_W-1:0] row_s5;
	chan_t                blur_s5 [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			last_s5 <= last_s4;
			col_s5  <= col_s4;
			row_s5  <= row_s4;
			for (int k = 0; k < NUM_CH; k++) begin
				blur_s5[k] <= lane_q[k];
			end
		end
	end

	assign out_valid  = v_s5;
	assign out_col    = col_s5;
	assign out_row    = row_s5;
	assign blur0      = blur_s5[0];
	assign blur1      = blur_s5[1];
	assign blur2      = blur_s5[2];
	assign frame_done = last_s5;

	// Checks
	a_blur_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (blur0 <= CH_W'(251)) && (blur1 <= CH_W'(251)) && (blur2 <= CH_W'(251)))
		else $error("blur result above kernel maximum");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WX'(col_q) < W_MAX) && (HX'(row_q) < H_MAX))
		else $error("position counter out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en4 |=> v_s4)
		else $error("stalled sum stage lost its request");

endmodule

>>> test/tb_top.sv
// tb_top: self-checking testbench for the 5x5 Gaussian blur top level.
// Depends on gb_pkg and gaussian_blur_5x5_rgb; results are compared against an
// in-bench line-buffer and window model of the filter, fed with accepted pixels.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gb_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 40;

	typedef struct packed {
		chan_t c0;
		chan_t c1;
		chan_t c2;
		logic  sof;
	} pixel_req_t;

	typedef struct packed {
		logic [OUT_COL_W-1:0] col;
		logic [OUT_ROW_W-1:0] row;
		chan_t                b0;
		chan_t                b1;
		chan_t                b2;
		logic                 done;
	} blur_res_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_write_t;

	// DUT ports
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	chan_t                 chan0       = '0;
	chan_t                 chan1       = '0;
	chan_t                 chan2       = '0;
	logic                  frame_start = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [OUT_COL_W-1:0]  out_col;
	logic [OUT_ROW_W-1:0]  out_row;
	chan_t                 blur0;
	chan_t                 blur1;
	chan_t                 blur2;
	logic                  frame_done;

	gaussian_blur_5x5_rgb u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.chan0       (chan0),
		.chan1       (chan1),
		.chan2       (chan2),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_col     (out_col),
		.out_row     (out_row),
		.blur0       (blur0),
		.blur1       (blur1),
		.blur2       (blur2),
		.frame_done  (frame_done)
	);

	always #5 clk = ~clk;

	// Bench state
	pixel_req_t pixel_q[$];
	blur_res_t  blur_expect_q[$];
	cfg_write_t cfg_q[$];
	int unsigned n_pushed       = 0;
	int unsigned n_accepted     = 0;
	int unsigned err_count      = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	pixel_req_t  next_px;

	// Filter model: geometry registers, row memory, window, position
	logic [IMG_W_W-1:0]   width_reg  = IMG_W_W'(RESET_WIDTH);
	logic [IMG_H_W-1:0]   height_reg = IMG_H_W'(RESET_HEIGHT);
	bit   [PIX_W-1:0]     row_mem [4][MAX_WIDTH_DEF];
	bit   [PIX_W-1:0]     win [KSIZE][KSIZE];
	logic [OUT_COL_W-1:0] col_pos = '0;
	logic [OUT_ROW_W-1:0] row_pos = '0;

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	function automatic int unsigned active_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
		return height_reg;
	endfunction

	// Kernel tap weight from distance to the center
	function automatic int unsigned tap_weight(input int r, input int c);
		int dr;
		int dc;
		dr = (r > 2) ? r - 2 : 2 - r;
		dc = (c > 2) ? c - 2 : 2 - c;
		if (dr == 2 && dc == 2) return WT_CORNER;
		if ((dr == 2 && dc == 1) || (dr == 1 && dc == 2)) return WT_EDGE1;
		if (dr == 2 || dc == 2) return WT_EDGE2;
		if (dr == 1 && dc == 1) return WT_INNER1;
		if (dr == 1 || dc == 1) return WT_INNER2;
		return WT_CENTER;
	endfunction

	function automatic chan_t window_blur(input int sh);
		int unsigned acc;
		acc = 0;
		for (int r = 0; r < KSIZE; r++)
			for (int c = 0; c < KSIZE; c++)
				acc += win[r][c][sh +: CH_W] * tap_weight(r, c);
		return chan_t'(acc / 1000);
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
				 input logic [CFG_DATA_W-1:0] data);
		if (idx == REG_WIDTH)
			width_reg = data[IMG_W_W-1:0];
		else if (idx == REG_HEIGHT)
			height_reg = data[IMG_H_W-1:0];
	endtask

	// Advance the filter model by one pixel and queue its blurred result, if any
	task automatic predict_blur(input pixel_req_t px);
		int unsigned wd;
		int unsigned ht;
		blur_res_t   res;
		wd = active_width();
		ht = active_height();
		if (px.sof) begin
			col_pos = '0;
			row_pos = '0;
		end
		for (int r = 0; r < KSIZE; r++)
			for (int c = 0; c < KSIZE - 1; c++)
				win[r][c] = win[r][c + 1];
		for (int r = 0; r < 4; r++)
			win[r][4] = row_mem[(row_pos + r) % 4][col_pos];
		win[4][4] = {px.c2, px.c1, px.c0};
		row_mem[row_pos % 4][col_pos] = win[4][4];

		if (col_pos >= 4 && row_pos >= 4 && col_pos < wd && row_pos < ht) begin
			res.col  = col_pos - 2;
			res.row  = row_pos - 2;
			res.b0   = window_blur(0);
			res.b1   = window_blur(CH_W);
			res.b2   = window_blur(2 * CH_W);
			res.done = (col_pos == wd - 1) && (row_pos == ht - 1);
			blur_expect_q.push_back(res);
		end

		if (col_pos + 1 >= wd) begin
			col_pos = '0;
			if (row_pos + 1 >= ht)
				row_pos = '0;
			else
				row_pos = row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	task automatic check_blur();
		blur_res_t want;
		if (blur_expect_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result col %0d row %0d", out_col, out_row));
		end else begin
			want = blur_expect_q.pop_front();
			if (out_col !== want.col)
				report_mismatch($sformatf("out_col got %0d want %0d", out_col, want.col));
			if (out_row !== want.row)
				report_mismatch($sformatf("out_row got %0d want %0d", out_row, want.row));
			if (blur0 !== want.b0)
				report_mismatch($sformatf("blur0 at (%0d,%0d) got %0d want %0d",
					want.col, want.row, blur0, want.b0));
			if (blur1 !== want.b1)
				report_mismatch($sformatf("blur1 at (%0d,%0d) got %0d want %0d",
					want.col, want.row, blur1, want.b1));
			if (blur2 !== want.b2)
				report_mismatch($sformatf("blur2 at (%0d,%0d) got %0d want %0d",
					want.col, want.row, blur2, want.b2));
			if (frame_done !== want.done)
				report_mismatch($sformatf("frame_done at (%0d,%0d) got %b want %b",
					want.col, want.row, frame_done, want.done));
		end
	endtask

	// Pixel driver: holds a request until accepted, then maybe idles
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			chan0       <= '0;
			chan1       <= '0;
			chan2       <= '0;
			frame_start <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				n_accepted++;
				predict_blur({chan0, chan1, chan2, frame_start});
			end
			if (in_valid && !in_ready) begin
				// hold the pending request
			end else if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_px      = pixel_q.pop_front();
				in_valid    <= 1'b1;
				chan0       <= next_px.c0;
				chan1       <= next_px.c1;
				chan2       <= next_px.c2;
				frame_start <= next_px.sof;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_blur();
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus helpers
	function automatic chan_t rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	task automatic push_px(input chan_t a, input chan_t b, input chan_t c, input logic sof);
		pixel_req_t req;
		req.c0  = a;
		req.c1  = b;
		req.c2  = c;
		req.sof = sof;
		pixel_q.push_back(req);
		n_pushed++;
	endtask

	task automatic push_rand(input int n, input bit sof_first, input int sof_pct);
		for (int i = 0; i < n; i++)
			push_px(rand_byte(), rand_byte(), rand_byte(),
				(i == 0 && sof_first) || ($urandom_range(99) < sof_pct));
	endtask

	// Drive queued register writes on the config channel
	task automatic program_regs();
		cfg_write_t wr;
		while (cfg_q.size() != 0) begin
			wr = cfg_q.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= wr.idx;
			cfg_data  <= wr.data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			apply_reg(wr.idx, wr.data);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write_t wr;
		wr.idx  = idx;
		wr.data = data;
		cfg_q.push_back(wr);
	endtask

	// Geometry write; unused upper data bits carry noise, sometimes a stray index
	task automatic set_size(input int wd, input int ht);
		queue_reg(REG_WIDTH, {4'($urandom_range(15)), IMG_W_W'(wd)});
		if ($urandom_range(3) == 0)
			queue_reg(CFG_IDX_W'($urandom_range(255, int'(REG_HEIGHT) + 1)),
				CFG_DATA_W'($urandom));
		queue_reg(REG_HEIGHT, {3'($urandom_range(7)), IMG_H_W'(ht)});
		program_regs();
	endtask

	// Wait until every request is taken and every result seen, then let the pipe drain
	task automatic wait_idle();
		@(posedge clk);
		while (n_accepted != n_pushed || blur_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int quota);
		int sent;
		int kind;
		int wd;
		int ht;
		int n;
		int cut;
		sent = 0;
		while (sent < quota) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				// small image: nothing should come out
				if ($urandom_range(1)) begin
					wd = $urandom_range(4, 0);
					ht = $urandom_range(9, 0);
				end else begin
					wd = $urandom_range(9, 0);
					ht = $urandom_range(4, 0);
				end
				set_size(wd, ht);
				push_rand(20, 1'b1, 5);
			end else begin
				wd = $urandom_range(12, 5);
				ht = $urandom_range(8, 5);
				set_size(wd, ht);
				if (kind < 70) begin
					// one or two frames, the second entered by row wrap
					n = wd * ht * $urandom_range(2, 1);
					push_rand(n, 1'b1, 0);
				end else if (kind < 85) begin
					// frame cut short by an early frame start
					cut = $urandom_range(wd * ht - 1, 1);
					push_rand(cut, 1'b1, 0);
					push_rand(wd * ht, 1'b1, 0);
					n = cut + wd * ht;
				end else begin
					n = $urandom_range(60, 20);
					push_rand(n, 1'b1, 8);
				end
				sent += n;
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		send_idle_pct  = 10;
		recv_stall_pct = 68;

		// Directed 5x5 frame: saturated, empty and checkered channels
		queue_reg(CFG_IDX_W'(255), CFG_DATA_W'(16'hFFFF));
		program_regs();
		set_size(5, 5);
		for (int i = 0; i < 25; i++)
			push_px(8'hFF, 8'h00, (((i / 5) + (i % 5)) % 2) ? 8'hFF : 8'h00, i == 0);
		wait_idle();

		// Geometry shrink mid-frame: counters beyond the new size, then row wrap
		set_size(12, 10);
		push_rand(94, 1'b1, 0);
		wait_idle();
		set_size(8, 9);
		push_rand(60, 1'b0, 0);
		wait_idle();
		queue_reg(REG_HEIGHT, CFG_DATA_W'(5));
		program_regs();
		push_rand(50, 1'b0, 0);
		wait_idle();

		// Images too small to emit, including zero sizes
		set_size(4, 6);
		push_rand(24, 1'b1, 0);
		wait_idle();
		set_size(6, 4);
		push_rand(24, 1'b1, 0);
		wait_idle();
		set_size(0, 7);
		push_rand(10, 1'b1, 0);
		wait_idle();
		set_size(7, 0);
		push_rand(10, 1'b1, 0);
		wait_idle();

		run_random(40);

		send_idle_pct  = 68;
		recv_stall_pct = 10;
		run_random(40);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(40);

		// Oversized registers saturate to the largest sizes
		set_size(12'hFFF, 5);
		push_rand(20, 1'b1, 0);
		wait_idle();
		set_size(5, 13'h1FFF);
		push_rand(5 * 6, 1'b1, 0);
		wait_idle();

		if (err_count == 0 && blur_expect_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(3_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
sv/gb_pkg.sv
sv/gb_linebuf.sv
sv/gb_lane.sv
sv/gaussian_blur_5x5_rgb.sv
test/tb_top.sv
